FILE: sv/udc_pkg.sv
// Shared types, register map and display constants for the up/down counter block.
`timescale 1ns / 1ps

package udc_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_DWELL      = 2'd2;

  localparam logic [7:0]  DEBOUNCE_RESET   = 8'd10;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;
  localparam logic [7:0]  DWELL_RESET      = 8'd5;

  localparam logic [7:0] SEG_BLANK = 8'hFF;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  digit_dwell_ticks;
  } udc_cfg_t;

  // Active-low seven-segment pattern for one decimal digit; codes above nine show nine.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pattern;
    case (digit)
      4'd0:    pattern = 8'hC0;
      4'd1:    pattern = 8'hF9;
      4'd2:    pattern = 8'hA4;
      4'd3:    pattern = 8'hB0;
      4'd4:    pattern = 8'h99;
      4'd5:    pattern = 8'h92;
      4'd6:    pattern = 8'h82;
      4'd7:    pattern = 8'hD8;
      4'd8:    pattern = 8'h80;
      default: pattern = 8'h90;
    endcase
    return pattern;
  endfunction

endpackage

FILE: sv/udc_if.sv
// Valid/ready channel interfaces for key ticks and display results.
`timescale 1ns / 1ps

interface udc_in_if;
  logic valid;
  logic ready;
  logic up_key;
  logic mode_key;
  logic down_key;

  modport source (output valid, output up_key, output mode_key, output down_key,
                  input ready);
  modport sink   (input valid, input up_key, input mode_key, input down_key,
                  output ready);
endinterface

interface udc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] digit_enable;
  logic [7:0] segments;
  logic [9:0] count_value;

  modport source (output valid, output digit_enable, output segments, output count_value,
                  input ready);
  modport sink   (input valid, input digit_enable, input segments, input count_value,
                  output ready);
endinterface

FILE: sv/udc_apb_regs.sv
// APB-style configuration registers for the up/down counter block.
`timescale 1ns / 1ps

module udc_apb_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output udc_pkg::udc_cfg_t cfg
);
  import udc_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= DEBOUNCE_RESET;
      cfg.long_press_ticks  <= LONG_PRESS_RESET;
      cfg.digit_dwell_ticks <= DWELL_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_DEBOUNCE:   cfg.debounce_ticks    <= pwdata[7:0];
        REG_LONG_PRESS: cfg.long_press_ticks  <= pwdata[15:0];
        REG_DWELL:      cfg.digit_dwell_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DEBOUNCE:   prdata = {24'd0, cfg.debounce_ticks};
      REG_LONG_PRESS: prdata = {16'd0, cfg.long_press_ticks};
      REG_DWELL:      prdata = {24'd0, cfg.digit_dwell_ticks};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/updown_counter_sevenseg_keys.sv
// Top level: tick-driven up/down counter with key debounce and a scanned display.
// Path: a tick transfer is captured in the input register, then goes through one pass of
// control logic into the result register, which takes it only when empty or draining.
// Throughput: one tick per cycle while the result channel is not stalled; the control
// state update is a loop closed through the control state registers.
// Reset (synchronous, active high) clears the count, starts paused waiting for a mode
// press, zeroes the timers and scan position, and restores the register defaults.
`timescale 1ns / 1ps

module updown_counter_sevenseg_keys #(
  parameter int COUNT_MODULUS = 1000
) (
  input  logic        clk,
  input  logic        rst,
  udc_in_if.sink      tick,
  udc_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import udc_pkg::*;

  // Largest count and its decimal digits, worked out at elaboration.
  localparam logic [9:0] COUNT_TOP = 10'(COUNT_MODULUS - 1);
  localparam logic [3:0] TOP_HUND  = 4'((COUNT_MODULUS - 1) / 100);
  localparam logic [3:0] TOP_TENS  = 4'(((COUNT_MODULUS - 1) / 10) % 10);
  localparam logic [3:0] TOP_ONES  = 4'((COUNT_MODULUS - 1) % 10);

  typedef enum logic [2:0] {
    ST_RUN         = 3'd0,
    ST_UP_DEB      = 3'd1,
    ST_UP_REL      = 3'd2,
    ST_DN_DEB      = 3'd3,
    ST_DN_REL      = 3'd4,
    ST_MODE_HOLD   = 3'd5,
    ST_PAUSE_PRESS = 3'd6,
    ST_WAIT_REL    = 3'd7
  } ctrl_state_t;

  udc_cfg_t cfg;

  udc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1: the accepted tick's key levels.
  logic s1_valid;
  logic s1_up;
  logic s1_mode;
  logic s1_down;

  // Stage 2 takes the tick when the result register is empty or drains this cycle.
  logic s2_take;
  assign s2_take    = s1_valid && (!result.valid || result.ready);
  assign tick.ready = !s1_valid || s2_take;

  // Control state. The count is held both in binary (for the count output) and as
  // three decimal digits (for the display), which step together.
  ctrl_state_t ctrl_state;
  logic [9:0]  count;
  logic [3:0]  hund;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [15:0] tick_timer;
  logic [1:0]  scan_digit;
  logic [7:0]  dwell_timer;

  ctrl_state_t ctrl_state_next;
  logic [9:0]  count_next;
  logic [3:0]  hund_next;
  logic [3:0]  tens_next;
  logic [3:0]  ones_next;
  logic [15:0] tick_timer_next;
  logic [1:0]  scan_digit_next;
  logic [7:0]  dwell_timer_next;
  logic [2:0]  en_next;
  logic [7:0]  seg_next;

  // Helper values for the next-state logic.
  logic [15:0] tick_inc;
  logic [15:0] hold_inc;
  logic [7:0]  dwell_inc;
  logic [1:0]  scan_cur;
  logic [3:0]  shown_digit;

  assign tick_inc  = tick_timer + 16'd1;
  assign hold_inc  = (tick_timer == 16'hFFFF) ? tick_timer : tick_inc;
  // The dwell timer is only loaded with values below the dwell setting, so this cannot wrap.
  // A dwell setting of zero compares like one, since dwell_inc is at least one.
  assign dwell_inc = dwell_timer + 8'd1;
  assign scan_cur  = (scan_digit == 2'd3) ? 2'd0 : scan_digit;

  always_comb begin
    case (scan_cur)
      2'd0:    shown_digit = hund;
      2'd1:    shown_digit = tens;
      default: shown_digit = ones;
    endcase
  end

  always_comb begin
    ctrl_state_next  = ctrl_state;
    count_next       = count;
    hund_next        = hund;
    tens_next        = tens;
    ones_next        = ones;
    tick_timer_next  = tick_timer;
    scan_digit_next  = scan_digit;
    dwell_timer_next = dwell_timer;
    en_next          = 3'd0;
    seg_next         = SEG_BLANK;

    case (ctrl_state)
      ST_RUN: begin
        // Up has priority over down, and down over mode. Any key blanks this tick
        // and restarts the scan at the hundreds digit.
        if (s1_up || s1_down || s1_mode) begin
          if (s1_up) begin
            ctrl_state_next = ST_UP_DEB;
          end else if (s1_down) begin
            ctrl_state_next = ST_DN_DEB;
          end else begin
            ctrl_state_next = ST_MODE_HOLD;
          end
          tick_timer_next  = 16'd0;
          scan_digit_next  = 2'd0;
          dwell_timer_next = 8'd0;
        end else begin
          en_next  = 3'(1 << scan_cur);
          seg_next = seg_pattern(shown_digit);
          if (dwell_inc >= cfg.digit_dwell_ticks) begin
            dwell_timer_next = 8'd0;
            scan_digit_next  = (scan_cur == 2'd2) ? 2'd0 : scan_cur + 2'd1;
          end else begin
            dwell_timer_next = dwell_inc;
            scan_digit_next  = scan_cur;
          end
        end
      end

      ST_UP_DEB, ST_DN_DEB: begin
        tick_timer_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.debounce_ticks}) begin
          tick_timer_next = 16'd0;
          if (ctrl_state == ST_UP_DEB) begin
            if (s1_up) begin
              ctrl_state_next = ST_UP_REL;
              if (count == COUNT_TOP) begin
                count_next = 10'd0;
                hund_next  = 4'd0;
                tens_next  = 4'd0;
                ones_next  = 4'd0;
              end else begin
                count_next = count + 10'd1;
                if (ones == 4'd9) begin
                  ones_next = 4'd0;
                  if (tens == 4'd9) begin
                    tens_next = 4'd0;
                    hund_next = hund + 4'd1;
                  end else begin
                    tens_next = tens + 4'd1;
                  end
                end else begin
                  ones_next = ones + 4'd1;
                end
              end
            end else begin
              ctrl_state_next = ST_RUN;
            end
          end else begin
            if (s1_down) begin
              ctrl_state_next = ST_DN_REL;
              if (count == 10'd0) begin
                count_next = COUNT_TOP;
                hund_next  = TOP_HUND;
                tens_next  = TOP_TENS;
                ones_next  = TOP_ONES;
              end else begin
                count_next = count - 10'd1;
                if (ones == 4'd0) begin
                  ones_next = 4'd9;
                  if (tens == 4'd0) begin
                    tens_next = 4'd9;
                    hund_next = hund - 4'd1;
                  end else begin
                    tens_next = tens - 4'd1;
                  end
                end else begin
                  ones_next = ones - 4'd1;
                end
              end
            end else begin
              ctrl_state_next = ST_RUN;
            end
          end
        end
      end

      ST_UP_REL: begin
        if (!s1_up) begin
          ctrl_state_next = ST_RUN;
        end
      end

      ST_DN_REL: begin
        if (!s1_down) begin
          ctrl_state_next = ST_RUN;
        end
      end

      ST_MODE_HOLD: begin
        // A short press ends in the pause; a hold that reaches the long-press
        // setting clears the count and resumes once the key is released.
        if (!s1_mode) begin
          tick_timer_next = 16'd0;
          ctrl_state_next = ST_PAUSE_PRESS;
        end else if (hold_inc >= cfg.long_press_ticks) begin
          count_next      = 10'd0;
          hund_next       = 4'd0;
          tens_next       = 4'd0;
          ones_next       = 4'd0;
          tick_timer_next = 16'd0;
          ctrl_state_next = ST_WAIT_REL;
        end else begin
          tick_timer_next = hold_inc;
        end
      end

      ST_WAIT_REL: begin
        if (!s1_mode) begin
          ctrl_state_next = ST_RUN;
        end
      end

      default: begin
        ctrl_state_next = s1_mode ? ST_WAIT_REL : ST_PAUSE_PRESS;
      end
    endcase
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
    if (tick.valid && tick.ready) begin
      s1_up   <= tick.up_key;
      s1_mode <= tick.mode_key;
      s1_down <= tick.down_key;
    end
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state   <= ST_PAUSE_PRESS;
      count        <= 10'd0;
      hund         <= 4'd0;
      tens         <= 4'd0;
      ones         <= 4'd0;
      tick_timer   <= 16'd0;
      scan_digit   <= 2'd0;
      dwell_timer  <= 8'd0;
      result.valid <= 1'b0;
    end else begin
      if (s2_take) begin
        ctrl_state   <= ctrl_state_next;
        count        <= count_next;
        hund         <= hund_next;
        tens         <= tens_next;
        ones         <= ones_next;
        tick_timer   <= tick_timer_next;
        scan_digit   <= scan_digit_next;
        dwell_timer  <= dwell_timer_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      result.digit_enable <= en_next;
      result.segments     <= seg_next;
      result.count_value  <= count_next;
    end
  end

  // The binary count stays in range and matches its decimal digits.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_TOP)
    else $error("count left its range");

  a_digits_match: assert property (@(posedge clk) disable iff (rst)
    (14'(hund) * 14'd100 + 14'(tens) * 14'd10 + 14'(ones)) == 14'(count))
    else $error("decimal digits disagree with the binary count");

  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl_state != ST_RUN |-> (scan_digit == 2'd0 && dwell_timer == 8'd0))
    else $error("scan position not reset outside run");

  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot0(result.digit_enable))
    else $error("more than one digit enabled");

  a_blank_segments: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.digit_enable == 3'd0) |-> result.segments == SEG_BLANK)
    else $error("segments lit while display blank");

endmodule
